### src/jkv_pkg.sv
// Shared types, constants and helper functions of the JSON key/value extractor.
// No dependencies; every other file of the block refers to it by scoped names.
package jkv_pkg;

  localparam int KEY_MAX_DEFAULT  = 16;
  localparam int NEST_MAX_DEFAULT = 255;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int KEY_LEN_W   = 5;
  localparam int STATUS_W    = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES_HIGH = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_KEY_MISSING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_COLON    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_QUOTE    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NO_BRACKET  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_NEST_OVER   = 3'd5;

  localparam logic [7:0] CHAR_COLON       = 8'h3A;
  localparam logic [7:0] CHAR_LBRACE      = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE      = 8'h7D;
  localparam logic [7:0] CHAR_LBRACKET    = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET    = 8'h5D;
  localparam logic [7:0] CHAR_COMMA       = 8'h2C;
  localparam logic [7:0] CHAR_QUOTE       = 8'h22;
  localparam logic [7:0] CHAR_SPACE       = 8'h20;
  localparam logic [7:0] CHAR_TAB         = 8'h09;
  localparam logic [7:0] CHAR_CR          = 8'h0D;

  // Role of one window cell in the key compare.
  localparam logic [1:0] MODE_IGNORE = 2'd0;
  localparam logic [1:0] MODE_KEY    = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic [7:0]          value_byte;
    logic                byte_valid;
    logic                run_last;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // Key bytes past the sixteenth read as zero.
  function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [5:0] idx);
    logic [2:0] sel;
    sel = idx[2:0];
    if (idx < 6'd8) begin
      return lo[sel*8 +: 8];
    end else if (idx < 6'd16) begin
      return hi[sel*8 +: 8];
    end
    return 8'h00;
  endfunction

endpackage

### src/json_key_value_extractor.sv
// Top level of the JSON key/value extractor: configuration, parse control, result path.
// Depends on jkv_pkg, jkv_window (with jkv_cell) and jkv_out_buf.
//
//   channel  | signals                                        | kind
//   text     | text_valid, text_ready, text_byte, end_of_text | valid/ready in
//   result   | result_valid, result_ready, value_byte,        | valid/ready out
//            | byte_valid, run_last, status                   |
//   cfg      | cfg_write_en, cfg_index, cfg_data              | write only
//
// One text item is taken per cycle unless text_ready is low; any result is buffered.
// Throughput is set by the two-entry result buffer: text_ready falls only when
// both entries hold results the consumer has not taken.
// After reset the block is ready at once; no clearing pass is needed.
// A stall on the result side holds the buffer and then stalls the text side.
module json_key_value_extractor #(
  parameter int KEY_MAX  = jkv_pkg::KEY_MAX_DEFAULT,
  parameter int NEST_MAX = jkv_pkg::NEST_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             text_valid,
  output logic                             text_ready,
  input  logic [7:0]                       text_byte,
  input  logic                             end_of_text,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic [7:0]                       value_byte,
  output logic                             byte_valid,
  output logic                             run_last,
  output logic [jkv_pkg::STATUS_W-1:0]     status,
  input  logic                             cfg_write_en,
  input  logic [jkv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [jkv_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LEN_W  = $clog2(KEY_MAX + 1);
  localparam int NEST_W = $clog2(NEST_MAX + 1);
  localparam logic [NEST_W-1:0] NEST_LIMIT = NEST_W'(NEST_MAX);

  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_COLON   = 3'd1;
  localparam logic [2:0] PH_VALUE   = 3'd2;
  localparam logic [2:0] PH_QUOTED  = 3'd3;
  localparam logic [2:0] PH_BRACKET = 3'd4;
  localparam logic [2:0] PH_BARE    = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  logic [jkv_pkg::KEY_LEN_W-1:0] key_length;
  logic [63:0]                   key_bytes_low;
  logic [63:0]                   key_bytes_high;
  logic [LEN_W-1:0]              eff_len;

  logic [2:0]        phase;
  logic [2:0]        phase_next;
  logic [NEST_W-1:0] nest_count;
  logic [NEST_W-1:0] nest_count_next;
  logic              bracket_kind;
  logic              bracket_kind_next;

  logic                accept;
  logic                key_found;
  logic                ws;
  logic [7:0]          open_c;
  logic [7:0]          close_c;
  logic                have;
  logic                vld;
  logic                last;
  logic [jkv_pkg::STATUS_W-1:0] st;
  jkv_pkg::cell_ctrl_t win_ctrl;
  jkv_pkg::result_t    res_in;
  jkv_pkg::result_t    res_out;
  logic                buf_can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= '0;
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        jkv_pkg::CFG_KEY_LENGTH:     key_length     <= cfg_data[jkv_pkg::KEY_LEN_W-1:0];
        jkv_pkg::CFG_KEY_BYTES_LOW:  key_bytes_low  <= cfg_data;
        jkv_pkg::CFG_KEY_BYTES_HIGH: key_bytes_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(key_length) > KEY_MAX) begin
      eff_len = LEN_W'(KEY_MAX);
    end else begin
      eff_len = LEN_W'(key_length);
    end
  end

  assign text_ready = buf_can_take;
  assign accept     = text_valid && text_ready;
  assign ws         = jkv_pkg::is_ws(text_byte);
  assign open_c     = bracket_kind ? jkv_pkg::CHAR_LBRACKET : jkv_pkg::CHAR_LBRACE;
  assign close_c    = bracket_kind ? jkv_pkg::CHAR_RBRACKET : jkv_pkg::CHAR_RBRACE;

  assign win_ctrl.shift = accept && (phase == PH_SEARCH);
  assign win_ctrl.clear = accept && end_of_text;

  jkv_window #(
    .KEY_MAX (KEY_MAX),
    .LEN_W   (LEN_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (win_ctrl),
    .in_byte   (text_byte),
    .key_len   (eff_len),
    .key_lo    (key_bytes_low),
    .key_hi    (key_bytes_high),
    .key_found (key_found)
  );

  always_comb begin
    phase_next        = phase;
    nest_count_next   = nest_count;
    bracket_kind_next = bracket_kind;
    have              = 1'b0;
    vld               = 1'b0;
    last              = 1'b0;
    st                = jkv_pkg::STATUS_OK;

    case (phase)
      PH_SEARCH: begin
        if (key_found) begin
          phase_next = PH_COLON;
        end
      end
      PH_COLON: begin
        if (!ws) begin
          if (text_byte == jkv_pkg::CHAR_COLON) begin
            phase_next = PH_VALUE;
          end else begin
            have       = 1'b1;
            last       = 1'b1;
            st         = jkv_pkg::STATUS_NO_COLON;
            phase_next = PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        if (!ws) begin
          if (text_byte == jkv_pkg::CHAR_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if ((text_byte == jkv_pkg::CHAR_LBRACE) ||
                       (text_byte == jkv_pkg::CHAR_LBRACKET)) begin
            phase_next        = PH_BRACKET;
            bracket_kind_next = (text_byte == jkv_pkg::CHAR_LBRACKET);
            nest_count_next   = NEST_W'(1);
            have              = 1'b1;
            vld               = 1'b1;
          end else if ((text_byte == jkv_pkg::CHAR_COMMA) ||
                       (text_byte == jkv_pkg::CHAR_RBRACE) ||
                       (text_byte == jkv_pkg::CHAR_RBRACKET)) begin
            have       = 1'b1;
            last       = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_BARE;
            have       = 1'b1;
            vld        = 1'b1;
          end
        end
      end
      PH_QUOTED: begin
        have = 1'b1;
        if (text_byte == jkv_pkg::CHAR_QUOTE) begin
          last       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          vld = 1'b1;
        end
      end
      PH_BRACKET: begin
        have = 1'b1;
        if ((text_byte == open_c) && (nest_count >= NEST_LIMIT)) begin
          last       = 1'b1;
          st         = jkv_pkg::STATUS_NEST_OVER;
          phase_next = PH_DONE;
        end else begin
          vld = 1'b1;
          if (text_byte == open_c) begin
            nest_count_next = nest_count + NEST_W'(1);
          end else if ((text_byte == close_c) && (nest_count != '0)) begin
            nest_count_next = nest_count - NEST_W'(1);
            if (nest_count == NEST_W'(1)) begin
              last       = 1'b1;
              phase_next = PH_DONE;
            end
          end
        end
      end
      PH_BARE: begin
        have = 1'b1;
        if ((text_byte == jkv_pkg::CHAR_COMMA) || (text_byte == jkv_pkg::CHAR_RBRACE) ||
            (text_byte == jkv_pkg::CHAR_RBRACKET) || ws) begin
          last       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          vld = 1'b1;
        end
      end
      default: ;
    endcase

    if (end_of_text) begin
      if (!last && (phase_next != PH_DONE)) begin
        case (phase_next)
          PH_SEARCH:  st = jkv_pkg::STATUS_KEY_MISSING;
          PH_COLON:   st = jkv_pkg::STATUS_NO_COLON;
          PH_QUOTED:  st = jkv_pkg::STATUS_NO_QUOTE;
          PH_BRACKET: st = jkv_pkg::STATUS_NO_BRACKET;
          default:    st = jkv_pkg::STATUS_OK;
        endcase
        have = 1'b1;
        last = 1'b1;
        if (st != jkv_pkg::STATUS_OK) begin
          vld = 1'b0;
        end
      end
      phase_next        = PH_SEARCH;
      nest_count_next   = '0;
      bracket_kind_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      nest_count   <= '0;
      bracket_kind <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      nest_count   <= nest_count_next;
      bracket_kind <= bracket_kind_next;
    end
  end

  assign res_in.value_byte = vld ? text_byte : 8'h00;
  assign res_in.byte_valid = vld;
  assign res_in.run_last   = last;
  assign res_in.status     = st;

  jkv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && have),
    .push_data (res_in),
    .can_take  (buf_can_take),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (res_out)
  );

  assign value_byte = res_out.value_byte;
  assign byte_valid = res_out.byte_valid;
  assign run_last   = res_out.run_last;
  assign status     = res_out.status;

  a_status_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !run_last) |-> (status == jkv_pkg::STATUS_OK))
    else $error("status set on a result that is not the closing one");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !byte_valid) |-> (value_byte == 8'h00))
    else $error("value_byte not zero on a result without a value character");

  a_text_end_clears: assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready && end_of_text) |=> ((phase == PH_SEARCH) && (nest_count == '0)))
    else $error("parse state not cleared after the last item of a text");

  a_bracket_nested: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BRACKET) |-> ((nest_count != '0) && (nest_count <= NEST_LIMIT)))
    else $error("nesting count out of range inside a bracketed value");

endmodule

### src/jkv_cell.sv
// One cell of the recent-text window: holds one byte, passes it on and checks it.
// Depends on jkv_pkg for the control struct, mode codes and the quote character.
module jkv_cell (
  input  logic               clk,
  input  logic               rst,
  input  jkv_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         prev_byte,
  input  logic               prev_filled,
  input  logic [1:0]         mode,
  input  logic [7:0]         expect_byte,
  output logic [7:0]         held_byte,
  output logic               filled,
  output logic               ok
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_byte <= prev_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      filled <= 1'b0;
    end else if (ctrl.shift) begin
      filled <= prev_filled;
    end
  end

  always_comb begin
    case (mode)
      jkv_pkg::MODE_KEY:   ok = (held_byte == expect_byte);
      jkv_pkg::MODE_CLOSE: ok = filled && (held_byte == jkv_pkg::CHAR_QUOTE);
      default:             ok = 1'b1;
    endcase
  end

endmodule

### src/jkv_window.sv
// Row of window cells and the quoted-key match over them.
// Depends on jkv_pkg and jkv_cell.
module jkv_window #(
  parameter int KEY_MAX = jkv_pkg::KEY_MAX_DEFAULT,
  parameter int LEN_W   = $clog2(KEY_MAX + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  jkv_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         in_byte,
  input  logic [LEN_W-1:0]   key_len,
  input  logic [63:0]        key_lo,
  input  logic [63:0]        key_hi,
  output logic               key_found
);

  localparam int CELLS = KEY_MAX + 1;

  logic [7:0]       cell_byte   [CELLS];
  logic             cell_filled [CELLS];
  logic [CELLS-1:0] cell_ok;
  logic [1:0]       cell_mode   [CELLS];
  logic [7:0]       cell_expect [CELLS];

  for (genvar q = 0; q < CELLS; q++) begin : g_cell
    logic [7:0] prev_byte;
    logic       prev_filled;

    if (q == 0) begin : g_head
      assign prev_byte   = in_byte;
      assign prev_filled = 1'b1;
    end else begin : g_body
      assign prev_byte   = cell_byte[q-1];
      assign prev_filled = cell_filled[q-1];
    end

    always_comb begin
      cell_expect[q] = 8'h00;
      if (int'(key_len) > q) begin
        cell_mode[q]   = jkv_pkg::MODE_KEY;
        cell_expect[q] = jkv_pkg::key_byte(key_lo, key_hi, 6'(int'(key_len) - 1 - q));
      end else if (int'(key_len) == q) begin
        cell_mode[q] = jkv_pkg::MODE_CLOSE;
      end else begin
        cell_mode[q] = jkv_pkg::MODE_IGNORE;
      end
    end

    jkv_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .prev_byte   (prev_byte),
      .prev_filled (prev_filled),
      .mode        (cell_mode[q]),
      .expect_byte (cell_expect[q]),
      .held_byte   (cell_byte[q]),
      .filled      (cell_filled[q]),
      .ok          (cell_ok[q])
    );
  end

  // The incoming byte is the closing quote; the cells hold the key and the opening quote.
  assign key_found = (in_byte == jkv_pkg::CHAR_QUOTE) && (&cell_ok);

endmodule

### src/jkv_out_buf.sv
// Two-entry result buffer that decouples the parser from the result channel.
// Depends on jkv_pkg for the result struct.
module jkv_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jkv_pkg::result_t  push_data,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_ready,
  output jkv_pkg::result_t  out_data
);

  jkv_pkg::result_t entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign can_take  = (count != 2'd2);
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for json_key_value_extractor: directed texts, then random texts
// under several key settings, checked result by result. Uses jkv_pkg and the RTL only.
module tb;

  localparam int KEY_LIM     = jkv_pkg::KEY_MAX_DEFAULT;
  localparam int NEST_LIM    = jkv_pkg::NEST_MAX_DEFAULT;
  localparam int WIN_D       = KEY_LIM + 2;
  localparam int ITEM_GOAL   = 1050;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [2:0] {
    SCAN_KEY, WANT_COLON, WANT_VALUE, IN_QUOTED, IN_BRACKET, IN_BARE, RUN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic [7:0]       b;
    logic             eot;
    logic             pinned;
    jkv_pkg::result_t pin_res;
  } text_item_t;

  localparam jkv_pkg::result_t NO_PIN = '0;

  // Rows marked pinned carry the result that must come back for that byte.
  localparam text_item_t DIRECTED_ROWS [28] = '{
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jkv_pkg::STATUS_KEY_MISSING}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COLON, 1'b0, 1'b0, NO_PIN},
    '{8'h37, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COMMA, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jkv_pkg::STATUS_OK}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{8'h78, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jkv_pkg::STATUS_NO_COLON}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COLON, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{8'h61, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jkv_pkg::STATUS_NO_QUOTE}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COLON, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_LBRACE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_RBRACE, 1'b1, 1'b1,
      '{jkv_pkg::CHAR_RBRACE, 1'b1, 1'b1, jkv_pkg::STATUS_OK}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COLON, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_TAB, 1'b0, 1'b0, NO_PIN},
    '{8'h39, 1'b1, 1'b1, '{8'h39, 1'b1, 1'b1, jkv_pkg::STATUS_OK}},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_QUOTE, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_COLON, 1'b0, 1'b0, NO_PIN},
    '{jkv_pkg::CHAR_RBRACKET, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, jkv_pkg::STATUS_OK}}
  };

  localparam logic [7:0] PUNCT [7] = '{
    jkv_pkg::CHAR_QUOTE, jkv_pkg::CHAR_COLON, jkv_pkg::CHAR_COMMA, jkv_pkg::CHAR_LBRACE,
    jkv_pkg::CHAR_RBRACE, jkv_pkg::CHAR_LBRACKET, jkv_pkg::CHAR_RBRACKET
  };

  logic clk;
  logic rst = 1'b1;
  logic text_valid = 1'b0;
  logic text_ready;
  logic [7:0] text_byte = 8'h00;
  logic end_of_text = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [7:0] value_byte;
  logic byte_valid;
  logic run_last;
  logic [jkv_pkg::STATUS_W-1:0] status;
  logic cfg_write_en = 1'b0;
  logic [jkv_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [jkv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic row_pinned = 1'b0;
  jkv_pkg::result_t row_pin_res = '0;
  logic calm = 1'b0;
  int hold_tick = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int cycle_count = 0;

  // Predictor copy of the registers and of the scan state.
  logic [4:0] key_len_r = '0;
  logic [63:0] key_lo_r = '0;
  logic [63:0] key_hi_r = '0;
  logic [7:0] recent [WIN_D] = '{default: 8'h00};
  int seen = 0;
  scan_phase_t phase = SCAN_KEY;
  int nest = 0;
  bit square = 1'b0;

  // Key as last programmed, used to build texts.
  logic [4:0] gen_len = '0;
  logic [63:0] gen_lo = '0;
  logic [63:0] gen_hi = '0;

  jkv_pkg::result_t expected_results [$];
  text_item_t text_q [$];
  int errors = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int settings_used = 0;
  int closing_seen [8] = '{default: 0};

  json_key_value_extractor #(.KEY_MAX(KEY_LIM), .NEST_MAX(NEST_LIM)) dut (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_ready(text_ready),
    .text_byte(text_byte), .end_of_text(end_of_text),
    .result_valid(result_valid), .result_ready(result_ready),
    .value_byte(value_byte), .byte_valid(byte_valid), .run_last(run_last), .status(status),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit blank(logic [7:0] c);
    return c == jkv_pkg::CHAR_SPACE || (c >= jkv_pkg::CHAR_TAB && c <= jkv_pkg::CHAR_CR);
  endfunction

  function automatic logic [7:0] key_at(logic [63:0] lo, logic [63:0] hi, int j);
    return (j < 8) ? lo[8*j +: 8] : hi[8*(j-8) +: 8];
  endfunction

  function automatic bit extract_step(input logic [7:0] b, input bit eot,
                                      output jkv_pkg::result_t r);
    bit have, vld, last, hit;
    logic [jkv_pkg::STATUS_W-1:0] st;
    logic [7:0] opn, cls;
    int len, i, j;
    have = 1'b0;
    vld = 1'b0;
    last = 1'b0;
    st = jkv_pkg::STATUS_OK;
    case (phase)
      SCAN_KEY: begin
        for (i = WIN_D - 1; i > 0; i--) recent[i] = recent[i-1];
        recent[0] = b;
        if (seen < WIN_D) seen++;
        len = (int'(key_len_r) > KEY_LIM) ? KEY_LIM : int'(key_len_r);
        hit = seen >= len + 2 && recent[0] == jkv_pkg::CHAR_QUOTE &&
              recent[len+1] == jkv_pkg::CHAR_QUOTE;
        for (j = 0; j < len; j++)
          if (recent[len-j] != key_at(key_lo_r, key_hi_r, j)) hit = 1'b0;
        if (hit) phase = WANT_COLON;
      end
      WANT_COLON: begin
        if (!blank(b)) begin
          if (b == jkv_pkg::CHAR_COLON) begin
            phase = WANT_VALUE;
          end else begin
            have = 1'b1;
            last = 1'b1;
            st = jkv_pkg::STATUS_NO_COLON;
            phase = RUN_DONE;
          end
        end
      end
      WANT_VALUE: begin
        if (!blank(b)) begin
          if (b == jkv_pkg::CHAR_QUOTE) begin
            phase = IN_QUOTED;
          end else if (b == jkv_pkg::CHAR_LBRACE || b == jkv_pkg::CHAR_LBRACKET) begin
            phase = IN_BRACKET;
            square = (b == jkv_pkg::CHAR_LBRACKET);
            nest = 1;
            have = 1'b1;
            vld = 1'b1;
          end else if (b == jkv_pkg::CHAR_COMMA || b == jkv_pkg::CHAR_RBRACE ||
                       b == jkv_pkg::CHAR_RBRACKET) begin
            have = 1'b1;
            last = 1'b1;
            phase = RUN_DONE;
          end else begin
            phase = IN_BARE;
            have = 1'b1;
            vld = 1'b1;
          end
        end
      end
      IN_QUOTED: begin
        have = 1'b1;
        if (b == jkv_pkg::CHAR_QUOTE) begin
          last = 1'b1;
          phase = RUN_DONE;
        end else begin
          vld = 1'b1;
        end
      end
      IN_BRACKET: begin
        opn = square ? jkv_pkg::CHAR_LBRACKET : jkv_pkg::CHAR_LBRACE;
        cls = square ? jkv_pkg::CHAR_RBRACKET : jkv_pkg::CHAR_RBRACE;
        have = 1'b1;
        if (b == opn && nest >= NEST_LIM) begin
          last = 1'b1;
          st = jkv_pkg::STATUS_NEST_OVER;
          phase = RUN_DONE;
        end else begin
          vld = 1'b1;
          if (b == opn) begin
            nest++;
          end else if (b == cls && nest > 0) begin
            nest--;
            if (nest == 0) begin
              last = 1'b1;
              phase = RUN_DONE;
            end
          end
        end
      end
      IN_BARE: begin
        have = 1'b1;
        if (b == jkv_pkg::CHAR_COMMA || b == jkv_pkg::CHAR_RBRACE ||
            b == jkv_pkg::CHAR_RBRACKET || blank(b)) begin
          last = 1'b1;
          phase = RUN_DONE;
        end else begin
          vld = 1'b1;
        end
      end
      default: ;
    endcase
    if (eot) begin
      if (!last && phase != RUN_DONE) begin
        case (phase)
          SCAN_KEY:   st = jkv_pkg::STATUS_KEY_MISSING;
          WANT_COLON: st = jkv_pkg::STATUS_NO_COLON;
          IN_QUOTED:  st = jkv_pkg::STATUS_NO_QUOTE;
          IN_BRACKET: st = jkv_pkg::STATUS_NO_BRACKET;
          default:    st = jkv_pkg::STATUS_OK;
        endcase
        have = 1'b1;
        last = 1'b1;
        if (st != jkv_pkg::STATUS_OK) vld = 1'b0;
      end
      foreach (recent[k]) recent[k] = 8'h00;
      seen = 0;
      phase = SCAN_KEY;
      nest = 0;
      square = 1'b0;
    end
    r.value_byte = vld ? b : 8'h00;
    r.byte_valid = vld;
    r.run_last = last;
    r.status = st;
    return have;
  endfunction

  always @(posedge clk) begin : check_results
    jkv_pkg::result_t predicted, want;
    bit have;
    if (!rst) begin
      if (cfg_write_en) begin
        case (cfg_index)
          jkv_pkg::CFG_KEY_LENGTH:     key_len_r = cfg_data[jkv_pkg::KEY_LEN_W-1:0];
          jkv_pkg::CFG_KEY_BYTES_LOW:  key_lo_r = cfg_data;
          jkv_pkg::CFG_KEY_BYTES_HIGH: key_hi_r = cfg_data;
          default: ;
        endcase
      end
      if (text_valid && text_ready) begin
        have = extract_step(text_byte, end_of_text, predicted);
        if (row_pinned) expected_results.push_back(row_pin_res);
        else if (have) expected_results.push_back(predicted);
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: value_byte %0h status %0d", value_byte, status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (value_byte !== want.value_byte) begin
            $error("value_byte: expected %0h, got %0h", want.value_byte, value_byte);
            errors++;
          end
          if (byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid);
            errors++;
          end
          if (run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, run_last);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          results_checked++;
          if (want.run_last) closing_seen[want.status]++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else if (hold_seen != hold_tick) begin
      hold_seen <= hold_tick;
      stall_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= int'($urandom_range(0, 12));
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic offer(input text_item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte <= it.b;
    end_of_text <= it.eot;
    row_pinned <= it.pinned;
    row_pin_res <= it.pin_res;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    text_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_key(input logic [4:0] len, input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_write_en <= 1'b1;
    cfg_index <= jkv_pkg::CFG_KEY_LENGTH;
    cfg_data <= {junk[63:jkv_pkg::KEY_LEN_W], len};
    @(posedge clk);
    cfg_index <= jkv_pkg::CFG_KEY_BYTES_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= jkv_pkg::CFG_KEY_BYTES_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    gen_len = len;
    gen_lo = lo;
    gen_hi = hi;
    settings_used++;
  endtask

  function automatic void put(logic [7:0] c);
    text_item_t t;
    t = '0;
    t.b = c;
    text_q.push_back(t);
  endfunction

  function automatic logic [7:0] ws_char();
    return ($urandom_range(0, 5) == 5) ? jkv_pkg::CHAR_SPACE
                                       : 8'(jkv_pkg::CHAR_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'(8'h61 + $urandom_range(0, 25));
      2: return ws_char();
      default: return PUNCT[$urandom_range(0, 6)];
    endcase
  endfunction

  function automatic void close_text();
    text_item_t t;
    t = text_q.pop_back();
    t.eot = 1'b1;
    text_q.push_back(t);
  endfunction

  task automatic make_text();
    int klen, j, depth, n;
    logic [7:0] opn, cls, c;
    text_q.delete();
    klen = (int'(gen_len) > KEY_LIM) ? KEY_LIM : int'(gen_len);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) put(noise_char());
      if ($urandom_range(0, 5) == 0) begin
        put(jkv_pkg::CHAR_QUOTE);
        for (j = 0; j + 1 < klen; j++) put(key_at(gen_lo, gen_hi, j));
        put(jkv_pkg::CHAR_QUOTE);
        put(jkv_pkg::CHAR_COLON);
      end
      put(jkv_pkg::CHAR_QUOTE);
      for (j = 0; j < klen; j++) put(key_at(gen_lo, gen_hi, j));
      put(jkv_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 2)) put(ws_char());
      if ($urandom_range(0, 9) != 0) put(jkv_pkg::CHAR_COLON);
      else put(noise_char());
      repeat ($urandom_range(0, 2)) put(ws_char());
      case ($urandom_range(0, 3))
        0: begin
          put(jkv_pkg::CHAR_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 255)); while (c == jkv_pkg::CHAR_QUOTE);
            put(c);
          end
          if ($urandom_range(0, 7) != 0) put(jkv_pkg::CHAR_QUOTE);
        end
        1: begin
          opn = $urandom_range(0, 1) ? jkv_pkg::CHAR_LBRACKET : jkv_pkg::CHAR_LBRACE;
          cls = (opn == jkv_pkg::CHAR_LBRACKET) ? jkv_pkg::CHAR_RBRACKET
                                                : jkv_pkg::CHAR_RBRACE;
          depth = 1;
          put(opn);
          repeat ($urandom_range(0, 8)) begin
            n = int'($urandom_range(0, 3));
            if (n == 0 && depth < 4) begin
              put(opn);
              depth++;
            end else if (n == 1 && depth > 1) begin
              put(cls);
              depth--;
            end else begin
              do c = 8'($urandom_range(32, 126)); while (c == opn || c == cls);
              put(c);
            end
          end
          if ($urandom_range(0, 7) != 0) repeat (depth) put(cls);
        end
        2: begin
          repeat ($urandom_range(1, 5)) begin
            do c = 8'($urandom_range(33, 255));
            while (c == jkv_pkg::CHAR_COMMA || c == jkv_pkg::CHAR_RBRACE ||
                   c == jkv_pkg::CHAR_RBRACKET || c == jkv_pkg::CHAR_QUOTE ||
                   c == jkv_pkg::CHAR_LBRACE || c == jkv_pkg::CHAR_LBRACKET);
            put(c);
          end
          case ($urandom_range(0, 4))
            0: put(jkv_pkg::CHAR_COMMA);
            1: put(jkv_pkg::CHAR_RBRACE);
            2: put(jkv_pkg::CHAR_RBRACKET);
            3: put(ws_char());
            default: ;
          endcase
        end
        default: begin
          case ($urandom_range(0, 3))
            0: put(jkv_pkg::CHAR_COMMA);
            1: put(jkv_pkg::CHAR_RBRACE);
            2: put(jkv_pkg::CHAR_RBRACKET);
            default: ;
          endcase
        end
      endcase
      repeat ($urandom_range(0, 3)) put(noise_char());
    end
    if ($urandom_range(0, 7) == 0 && text_q.size() > 1) begin
      n = int'($urandom_range(1, text_q.size() - 1));
      while (text_q.size() > n) void'(text_q.pop_back());
    end
    close_text();
  endtask

  task automatic send_text();
    foreach (text_q[i]) offer(text_q[i]);
    texts_sent++;
  endtask

  initial begin : stimulus
    logic [127:0] kbits;
    logic [4:0] klen_pick;
    int setting, start, j;
    bit letters;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_ROWS[i]) offer(DIRECTED_ROWS[i]);
    texts_sent += 7;
    drain();

    setting = 0;
    while (bytes_sent < ITEM_GOAL) begin
      case (setting)
        0: load_key(5'd16, '1, '1);
        1: load_key(5'd31, '0, '0);
        2: load_key(5'd0, {$urandom, $urandom}, {$urandom, $urandom});
        3: load_key(5'd2, 64'h6469, 64'h0);
        default: begin
          letters = $urandom_range(0, 1);
          for (j = 0; j < 16; j++)
            kbits[8*j +: 8] = letters ? 8'(8'h61 + $urandom_range(0, 25))
                                      : 8'($urandom_range(0, 255));
          klen_pick = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(1, 8));
          load_key(klen_pick, kbits[63:0], kbits[127:64]);
        end
      endcase
      if (setting == 2) hold_tick <= hold_tick + 1;
      if (setting == 3) begin
        // One bracket more than the nesting limit allows.
        text_q.delete();
        put(jkv_pkg::CHAR_QUOTE);
        put(8'h69);
        put(8'h64);
        put(jkv_pkg::CHAR_QUOTE);
        put(jkv_pkg::CHAR_COLON);
        repeat (NEST_LIM + 1) put(jkv_pkg::CHAR_LBRACKET);
        put(8'h78);
        close_text();
        send_text();
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS && bytes_sent < ITEM_GOAL) begin
        if (bytes_sent >= ITEM_GOAL - 150) calm <= 1'b1;
        make_text();
        send_text();
      end
      drain();
      setting++;
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("Sent %0d texts (%0d bytes) under %0d key settings; checked %0d results.",
             texts_sent, bytes_sent, settings_used, results_checked);
    $display("Closing statuses: ok %0d, key missing %0d, no colon %0d, %s %0d, %s %0d, %s %0d.",
             closing_seen[jkv_pkg::STATUS_OK], closing_seen[jkv_pkg::STATUS_KEY_MISSING],
             closing_seen[jkv_pkg::STATUS_NO_COLON],
             "no quote", closing_seen[jkv_pkg::STATUS_NO_QUOTE],
             "no bracket", closing_seen[jkv_pkg::STATUS_NO_BRACKET],
             "nesting overflow", closing_seen[jkv_pkg::STATUS_NEST_OVER]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
